// ===== design/b58td_pkg.sv =====
// ----------------------------------------------------------------------------
// b58td_pkg
// Types and constants shared by the Base58 text decoder front and back ends.
// ----------------------------------------------------------------------------
package b58td_pkg;

   localparam int MAX_CHARS_DEFAULT   = 64;
   localparam int STORE_BYTES_DEFAULT = 48;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_W     = 2;

   localparam int COUNT_W     = 7;
   localparam int DIGIT_W     = 6;
   localparam int SUM_W       = 14;

   localparam logic [COUNT_W-1:0] COUNT_MAX   = 7'd127;
   localparam logic [COUNT_W-1:0] MAX_RESULTS = 7'd64;
   localparam logic [7:0]         CHAR_ONE    = 8'h31;
   localparam logic [7:0]         CHAR_SPACE  = 8'h20;
   localparam logic [DIGIT_W-1:0] RADIX       = 6'd58;

   typedef enum logic [2:0] {
      CLS_NUL,
      CLS_SPACE,
      CLS_ONE,
      CLS_DIGIT,
      CLS_BAD
   } char_class_type;

   typedef enum logic [1:0] {
      ST_OK         = 2'd0,
      ST_BAD_CHAR   = 2'd1,
      ST_TRAIL_TEXT = 2'd2,
      ST_TOO_LONG   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      PH_LEAD,
      PH_ONES,
      PH_DIGITS,
      PH_TRAIL
   } phase_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_FOLD_START,
      S_FOLD,
      S_WRAP,
      S_STRIP_RD,
      S_STRIP_CHK,
      S_ONES,
      S_BYTE_RD,
      S_BYTE_OUT,
      S_EMPTY,
      S_ERROR
   } back_state_type;

   typedef struct packed {
      char_class_type     cls;
      logic [DIGIT_W-1:0] digit;
      logic               last;
   } b58td_item_type;

endpackage

// ===== design/b58td_front.sv =====
// ----------------------------------------------------------------------------
// b58td_front
// Accepts text characters, classifies them against the Base58 alphabet and
// queues the classified items for the back end.
// ----------------------------------------------------------------------------
module b58td_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [7:0]               req_tdata,   // [7:0] char_code
   input  logic                     req_tlast,
   output logic                     q_valid,
   output b58td_pkg::b58td_item_type q_item,
   input  logic                     q_pop
);
   import b58td_pkg::*;

   b58td_item_type       slot_ff [QUEUE_DEPTH];
   logic [QUEUE_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_W:0]     fill_ff, fill_in;
   b58td_item_type       class_item;
   logic                 push;
   logic                 is_space;
   logic                 digit_ok;
   logic [DIGIT_W-1:0]   digit_val;

   always_comb begin
      digit_ok  = 1'b1;
      digit_val = '0;
      if (req_tdata >= 8'h31 && req_tdata <= 8'h39) begin
         digit_val = DIGIT_W'(req_tdata - 8'h31);
      end else if (req_tdata >= 8'h41 && req_tdata <= 8'h48) begin
         digit_val = DIGIT_W'(req_tdata - 8'h41 + 8'd9);
      end else if (req_tdata >= 8'h4A && req_tdata <= 8'h4E) begin
         digit_val = DIGIT_W'(req_tdata - 8'h4A + 8'd17);
      end else if (req_tdata >= 8'h50 && req_tdata <= 8'h5A) begin
         digit_val = DIGIT_W'(req_tdata - 8'h50 + 8'd22);
      end else if (req_tdata >= 8'h61 && req_tdata <= 8'h6B) begin
         digit_val = DIGIT_W'(req_tdata - 8'h61 + 8'd33);
      end else if (req_tdata >= 8'h6D && req_tdata <= 8'h7A) begin
         digit_val = DIGIT_W'(req_tdata - 8'h6D + 8'd44);
      end else begin
         digit_ok = 1'b0;
      end
   end

   assign is_space = (req_tdata == CHAR_SPACE) || (req_tdata >= 8'h09 && req_tdata <= 8'h0D);

   always_comb begin
      class_item.digit = digit_val;
      class_item.last  = req_tlast;
      priority if (req_tdata == 8'h00) begin
         class_item.cls = CLS_NUL;
      end else if (is_space) begin
         class_item.cls = CLS_SPACE;
      end else if (req_tdata == CHAR_ONE) begin
         class_item.cls = CLS_ONE;
      end else if (digit_ok) begin
         class_item.cls = CLS_DIGIT;
      end else begin
         class_item.cls = CLS_BAD;
      end
   end

   assign req_tready = (fill_ff != (QUEUE_W + 1)'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready;
   assign q_valid    = (fill_ff != '0);
   assign q_item     = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push  ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = q_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff + (QUEUE_W + 1)'(push) - (QUEUE_W + 1)'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= class_item;
      end
   end

endmodule

// ===== design/b58td_back.sv =====
// ----------------------------------------------------------------------------
// b58td_back
// Runs the scan phases, folds digits into the byte store one byte per cycle
// and emits the decoded bytes or an error item at the end of each string.
// ----------------------------------------------------------------------------
module b58td_back #(
   parameter int MAX_CHARS   = b58td_pkg::MAX_CHARS_DEFAULT,
   parameter int STORE_BYTES = b58td_pkg::STORE_BYTES_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  b58td_pkg::b58td_item_type q_item,
   output logic                      q_pop,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [7:0]                rsp_tdata,   // [7:0] out_byte
   output logic [2:0]                rsp_tuser,   // [0] has_byte, [2:1] status
   output logic                      rsp_tlast
);
   import b58td_pkg::*;

   localparam int IDX_W = $clog2(STORE_BYTES);
   localparam int USE_W = $clog2(STORE_BYTES + 1);
   localparam logic [USE_W-1:0]   StoreLim  = USE_W'(STORE_BYTES);
   localparam logic [COUNT_W-1:0] CharLimit = COUNT_W'(MAX_CHARS);

   logic [7:0]           store_mem [STORE_BYTES];
   logic [7:0]           rd_data_ff;
   logic [IDX_W-1:0]     rd_addr;
   logic                 mem_we;
   logic [IDX_W-1:0]     wr_addr;
   logic [7:0]           wr_data;

   back_state_type       state_ff, state_in;
   phase_type            phase_ff, phase_in;
   status_type           err_ff, err_in;
   logic [COUNT_W-1:0]   chars_ff, chars_in;
   logic [COUNT_W-1:0]   ones_ff, ones_in;
   logic [COUNT_W-1:0]   kcnt_ff, kcnt_in;
   logic [COUNT_W-1:0]   emit_ff, emit_in;
   logic [USE_W-1:0]     in_use_ff, in_use_in;
   logic [USE_W-1:0]     idx_ff, idx_in;
   logic [USE_W-1:0]     top_ff, top_in;
   logic [DIGIT_W-1:0]   carry_ff, carry_in;
   logic                 last_ff, last_in;

   logic                 out_valid_ff, out_valid_in;
   logic [7:0]           out_byte_ff, out_byte_in;
   logic                 out_has_ff, out_has_in;
   status_type           out_status_ff, out_status_in;
   logic                 out_last_ff, out_last_in;

   logic                 out_free;
   logic                 take;
   logic                 fold_go;
   logic                 fold_more;
   logic [COUNT_W-1:0]   chars_inc;
   status_type           err_scan;
   phase_type            phase_scan;
   logic [COUNT_W-1:0]   ones_scan;
   logic                 digit_take;
   logic [7:0]           fold_byte;
   logic [SUM_W-1:0]     fold_sum;
   logic [USE_W-1:0]     idx_next;
   logic [USE_W-1:0]     top_m1;
   logic                 ones_done;
   logic                 ones_last;
   logic                 byte_last;
   logic                 cap_hit;

   assign out_free = !out_valid_ff || rsp_tready;
   assign take     = (state_ff == S_IDLE) && q_valid;
   assign q_pop    = take;

   // scan one classified character
   always_comb begin
      chars_inc  = (chars_ff == COUNT_MAX) ? chars_ff : chars_ff + 1'b1;
      err_scan   = (chars_inc > CharLimit) ? ST_TOO_LONG : err_ff;
      phase_scan = phase_ff;
      ones_scan  = ones_ff;
      digit_take = 1'b0;
      if (q_item.cls == CLS_NUL) begin
         if (err_scan != ST_TOO_LONG) begin
            err_scan = ST_BAD_CHAR;
         end
      end else if (err_scan == ST_OK) begin
         unique case (phase_ff)
            PH_LEAD: begin
               unique case (q_item.cls)
                  CLS_SPACE: ;
                  CLS_ONE: begin
                     phase_scan = PH_ONES;
                     ones_scan  = COUNT_W'(1);
                  end
                  CLS_DIGIT: begin
                     phase_scan = PH_DIGITS;
                     digit_take = 1'b1;
                  end
                  default: err_scan = ST_BAD_CHAR;
               endcase
            end
            PH_ONES: begin
               unique case (q_item.cls)
                  CLS_ONE: begin
                     if (ones_ff != COUNT_MAX) begin
                        ones_scan = ones_ff + 1'b1;
                     end
                  end
                  CLS_SPACE: phase_scan = PH_TRAIL;
                  CLS_DIGIT: begin
                     phase_scan = PH_DIGITS;
                     digit_take = 1'b1;
                  end
                  default: err_scan = ST_BAD_CHAR;
               endcase
            end
            PH_DIGITS: begin
               unique case (q_item.cls)
                  CLS_SPACE: phase_scan = PH_TRAIL;
                  CLS_ONE, CLS_DIGIT: digit_take = 1'b1;
                  default: err_scan = ST_BAD_CHAR;
               endcase
            end
            default: begin
               if (q_item.cls != CLS_SPACE) begin
                  err_scan = ST_TRAIL_TEXT;
               end
            end
         endcase
      end
   end

   assign fold_go   = digit_take && ((q_item.digit != '0) || (in_use_ff != '0));
   assign fold_byte = (idx_ff < in_use_ff) ? rd_data_ff : 8'h00;
   assign fold_sum  = SUM_W'(carry_ff) + SUM_W'(fold_byte) * SUM_W'(RADIX);
   assign idx_next  = idx_ff + 1'b1;
   assign fold_more = ((fold_sum[SUM_W-1:8] != '0) || (idx_next < in_use_ff))
                      && (idx_next < StoreLim);
   assign top_m1    = top_ff - 1'b1;
   assign cap_hit   = (emit_ff == MAX_RESULTS - 1'b1);
   assign ones_done = (kcnt_ff + 1'b1 == ones_ff);
   assign ones_last = (ones_done && top_ff == '0) || cap_hit;
   assign byte_last = (top_ff == USE_W'(1)) || cap_hit;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               if (fold_go) begin
                  state_in = S_FOLD_START;
               end else if (q_item.last) begin
                  state_in = S_WRAP;
               end
            end
         end
         S_FOLD_START: state_in = S_FOLD;
         S_FOLD: begin
            if (!fold_more) begin
               state_in = last_ff ? S_WRAP : S_IDLE;
            end
         end
         S_WRAP: begin
            if (err_ff != ST_OK) begin
               state_in = S_ERROR;
            end else if (in_use_ff != '0) begin
               state_in = S_STRIP_RD;
            end else begin
               state_in = (ones_ff == '0) ? S_EMPTY : S_ONES;
            end
         end
         S_STRIP_RD: state_in = S_STRIP_CHK;
         S_STRIP_CHK: begin
            if (rd_data_ff == 8'h00) begin
               if (top_ff == USE_W'(1)) begin
                  state_in = (ones_ff == '0) ? S_EMPTY : S_ONES;
               end else begin
                  state_in = S_STRIP_RD;
               end
            end else begin
               state_in = (ones_ff == '0) ? S_BYTE_OUT : S_ONES;
            end
         end
         S_ONES: begin
            if (out_free) begin
               if (ones_last) begin
                  state_in = S_IDLE;
               end else if (ones_done) begin
                  state_in = S_BYTE_RD;
               end
            end
         end
         S_BYTE_RD: state_in = S_BYTE_OUT;
         S_BYTE_OUT: begin
            if (out_free) begin
               state_in = byte_last ? S_IDLE : S_BYTE_RD;
            end
         end
         S_EMPTY, S_ERROR: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      phase_in      = phase_ff;
      err_in        = err_ff;
      chars_in      = chars_ff;
      ones_in       = ones_ff;
      kcnt_in       = kcnt_ff;
      emit_in       = emit_ff;
      in_use_in     = in_use_ff;
      idx_in        = idx_ff;
      top_in        = top_ff;
      carry_in      = carry_ff;
      last_in       = last_ff;
      rd_addr       = top_m1[IDX_W-1:0];
      mem_we        = 1'b0;
      wr_addr       = idx_ff[IDX_W-1:0];
      wr_data       = fold_sum[7:0];
      out_valid_in  = out_valid_ff && !rsp_tready;
      out_byte_in   = out_byte_ff;
      out_has_in    = out_has_ff;
      out_status_in = out_status_ff;
      out_last_in   = out_last_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (take) begin
               chars_in = chars_inc;
               err_in   = err_scan;
               phase_in = phase_scan;
               ones_in  = ones_scan;
               last_in  = q_item.last;
               carry_in = q_item.digit;
               idx_in   = '0;
            end
         end
         S_FOLD_START: rd_addr = '0;
         S_FOLD: begin
            rd_addr  = (idx_next < StoreLim) ? idx_next[IDX_W-1:0] : '0;
            mem_we   = 1'b1;
            carry_in = DIGIT_W'(fold_sum[SUM_W-1:8]);
            idx_in   = idx_next;
            if (!fold_more) begin
               in_use_in = idx_next;
            end
         end
         S_WRAP: begin
            top_in  = in_use_ff;
            kcnt_in = '0;
            emit_in = '0;
         end
         S_STRIP_CHK: begin
            if (rd_data_ff == 8'h00) begin
               top_in = top_m1;
            end
         end
         S_ONES: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_byte_in   = 8'h00;
               out_has_in    = 1'b1;
               out_status_in = ST_OK;
               out_last_in   = ones_last;
               kcnt_in       = kcnt_ff + 1'b1;
               emit_in       = emit_ff + 1'b1;
            end
         end
         S_BYTE_OUT: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_byte_in   = rd_data_ff;
               out_has_in    = 1'b1;
               out_status_in = ST_OK;
               out_last_in   = byte_last;
               top_in        = top_m1;
               emit_in       = emit_ff + 1'b1;
            end
         end
         S_EMPTY, S_ERROR: begin
            if (out_free) begin
               out_valid_in  = 1'b1;
               out_byte_in   = 8'h00;
               out_has_in    = 1'b0;
               out_status_in = err_ff;
               out_last_in   = 1'b1;
            end
         end
         default: ;
      endcase
      // clear the string state once the final item is out
      if ((state_ff != S_IDLE) && (state_in == S_IDLE) && (state_ff != S_FOLD)) begin
         phase_in  = PH_LEAD;
         err_in    = ST_OK;
         chars_in  = '0;
         ones_in   = '0;
         in_use_in = '0;
         last_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         phase_ff     <= PH_LEAD;
         err_ff       <= ST_OK;
         chars_ff     <= '0;
         ones_ff      <= '0;
         kcnt_ff      <= '0;
         emit_ff      <= '0;
         in_use_ff    <= '0;
         idx_ff       <= '0;
         top_ff       <= '0;
         last_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         err_ff       <= err_in;
         chars_ff     <= chars_in;
         ones_ff      <= ones_in;
         kcnt_ff      <= kcnt_in;
         emit_ff      <= emit_in;
         in_use_ff    <= in_use_in;
         idx_ff       <= idx_in;
         top_ff       <= top_in;
         last_ff      <= last_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff      <= carry_in;
      out_byte_ff   <= out_byte_in;
      out_has_ff    <= out_has_in;
      out_status_ff <= out_status_in;
      out_last_ff   <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= store_mem[rd_addr];
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_byte_ff;
   assign rsp_tuser  = {out_status_ff, out_has_ff};
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== design/base58_text_decoder.sv =====
// ----------------------------------------------------------------------------
// base58_text_decoder
// Decodes Base58 text (Bitcoin alphabet), one character per input item.
// ----------------------------------------------------------------------------
// One character enters per item, tlast on the final one. Characters pass
// through a four-item queue to the scan engine, which handles blanks and
// leading '1' characters directly and folds a digit into the byte store
// one store byte per cycle through the multiply-by-58 carry step. After
// the final character the decoder wraps up, reads bytes from the top of
// the store down to the first nonzero one, then sends one item per cycle
// for the leading zero bytes while the output is not stalled, then reads
// each store byte and sends it as an item.
// Errors and empty strings give a single item with has_byte low. The store
// needs no clearing pass: bytes above the in-use count read as zero.
module base58_text_decoder #(
   parameter int MAX_CHARS   = b58td_pkg::MAX_CHARS_DEFAULT,
   parameter int STORE_BYTES = b58td_pkg::STORE_BYTES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_code
   input  logic       req_tlast,   // end_of_text
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [2:0] rsp_tuser,   // [0] has_byte, [2:1] status
   output logic       rsp_tlast    // last_result
);
   import b58td_pkg::*;

   logic           q_valid;
   logic           q_pop;
   b58td_item_type q_item;

   b58td_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   b58td_back #(
      .MAX_CHARS   (MAX_CHARS),
      .STORE_BYTES (STORE_BYTES)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

// ===== verif/tb_base58_text_decoder.sv =====
// ----------------------------------------------------------------------------
// tb_base58_text_decoder
// Self-checking bench for the Base58 text decoder. Strings of characters are
// sent one per item; scripted rows carry expected items, a built-in decoder
// predicts the rest, and every returned item is checked in order.
// A short scripted part covers blanks, leading ones, bad characters, NUL and
// text after trailing blanks; random strings follow, mostly well formed, with
// broken strings, noise and long strings near the length limit mixed in.
// ----------------------------------------------------------------------------
module tb_base58_text_decoder;
   timeunit 1ns;
   timeprecision 1ps;

   import b58td_pkg::*;

   localparam int MAX_CHARS    = MAX_CHARS_DEFAULT;
   localparam int STORE_BYTES  = STORE_BYTES_DEFAULT;
   localparam int RANDOM_ITEMS = 256;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int HOLD_CYCLES  = 400;
   localparam int SCRIPT_ROWS  = 24;

   typedef struct packed {
      logic [7:0] value;
      logic       present;
      status_type code;
      logic       final_item;
   } decoded_item_type;

   typedef struct packed {
      logic [7:0]       ch;
      logic             tail;
      logic             typed;
      decoded_item_type want;
   } stim_row_type;

   localparam decoded_item_type NO_RESULT = '{8'h00, 1'b0, ST_OK, 1'b0};

   localparam stim_row_type SCRIPT [SCRIPT_ROWS] = '{
      '{8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, ST_BAD_CHAR, 1'b1}},
      '{8'h20, 1'b1, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b1}},
      '{8'h31, 1'b1, 1'b1, '{8'h00, 1'b1, ST_OK, 1'b1}},
      '{8'h7A, 1'b1, 1'b1, '{8'h39, 1'b1, ST_OK, 1'b1}},
      '{8'h32, 1'b1, 1'b1, '{8'h01, 1'b1, ST_OK, 1'b1}},
      '{8'h30, 1'b1, 1'b1, '{8'h00, 1'b0, ST_BAD_CHAR, 1'b1}},
      '{8'hFF, 1'b1, 1'b1, '{8'h00, 1'b0, ST_BAD_CHAR, 1'b1}},
      '{8'h31, 1'b0, 1'b0, NO_RESULT},
      '{8'h20, 1'b0, 1'b0, NO_RESULT},
      '{8'h61, 1'b1, 1'b1, '{8'h00, 1'b0, ST_TRAIL_TEXT, 1'b1}},
      '{8'h09, 1'b0, 1'b0, NO_RESULT},
      '{8'h31, 1'b0, 1'b0, NO_RESULT},
      '{8'h31, 1'b0, 1'b0, NO_RESULT},
      '{8'h7A, 1'b0, 1'b0, NO_RESULT},
      '{8'h0D, 1'b1, 1'b0, NO_RESULT},
      '{8'h4F, 1'b0, 1'b0, NO_RESULT},
      '{8'h6C, 1'b1, 1'b1, '{8'h00, 1'b0, ST_BAD_CHAR, 1'b1}},
      '{8'h35, 1'b0, 1'b0, NO_RESULT},
      '{8'h51, 1'b1, 1'b0, NO_RESULT},
      '{8'h0B, 1'b0, 1'b0, NO_RESULT},
      '{8'h0C, 1'b1, 1'b1, '{8'h00, 1'b0, ST_OK, 1'b1}},
      '{8'h49, 1'b0, 1'b0, NO_RESULT},
      '{8'h00, 1'b0, 1'b0, NO_RESULT},
      '{8'h80, 1'b1, 1'b1, '{8'h00, 1'b0, ST_BAD_CHAR, 1'b1}}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       req_tvalid;
   logic       req_tready;
   logic [7:0] req_tdata;
   logic       req_tlast;
   logic       rsp_tvalid;
   logic       rsp_tready;
   logic [7:0] rsp_tdata;
   logic [2:0] rsp_tuser;
   logic       rsp_tlast;

   base58_text_decoder dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #4 clock = ~clock;

   string            digit_chars = "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";
   logic [7:0]       acc_store [STORE_BYTES];
   int unsigned      acc_used;
   int unsigned      ones_count;
   int unsigned      chars_count;
   phase_type        scan_at;
   status_type       fault;
   decoded_item_type step_out [$];
   decoded_item_type decoded_q [$];
   logic [7:0]       text [$];
   int unsigned      sent;
   int unsigned      mismatches;
   int unsigned      cycle_count;
   int unsigned      hold_left;
   bit               calm;
   bit               stall_req;

   function automatic bit is_blank(input logic [7:0] ch);
      return ch == CHAR_SPACE || (ch >= 8'h09 && ch <= 8'h0D);
   endfunction

   function automatic int digit_value(input logic [7:0] ch);
      for (int i = 0; i < 58; i++) begin
         if (digit_chars[i] == ch) return i;
      end
      return -1;
   endfunction

   function automatic void clear_state();
      foreach (acc_store[i]) acc_store[i] = 8'h00;
      acc_used    = 0;
      ones_count  = 0;
      chars_count = 0;
      scan_at     = PH_LEAD;
      fault       = ST_OK;
   endfunction

   function automatic void fold_value(input int unsigned d);
      int unsigned carry;
      int unsigned i;
      carry = d;
      i = 0;
      while ((carry != 0 || i < acc_used) && i < STORE_BYTES) begin
         carry += int'(acc_store[i]) * int'(RADIX);
         acc_store[i] = carry[7:0];
         carry >>= 8;
         i++;
      end
      acc_used = i;
   endfunction

   function automatic void decode_char(input logic [7:0] ch, input logic tail);
      int               d;
      bit               blank;
      int unsigned      top;
      decoded_item_type item;
      d = digit_value(ch);
      blank = is_blank(ch);
      step_out.delete();
      if (chars_count < COUNT_MAX) chars_count++;
      if (chars_count > MAX_CHARS) fault = ST_TOO_LONG;
      if (ch == 8'h00) begin
         if (fault != ST_TOO_LONG) fault = ST_BAD_CHAR;
      end else if (fault == ST_OK) begin
         case (scan_at)
            PH_LEAD: begin
               if (blank) begin
               end else if (ch == CHAR_ONE) begin
                  scan_at = PH_ONES;
                  ones_count = 1;
               end else if (d < 0) begin
                  fault = ST_BAD_CHAR;
               end else begin
                  scan_at = PH_DIGITS;
                  fold_value(d);
               end
            end
            PH_ONES: begin
               if (ch == CHAR_ONE) begin
                  if (ones_count < COUNT_MAX) ones_count++;
               end else if (blank) begin
                  scan_at = PH_TRAIL;
               end else if (d < 0) begin
                  fault = ST_BAD_CHAR;
               end else begin
                  scan_at = PH_DIGITS;
                  fold_value(d);
               end
            end
            PH_DIGITS: begin
               if (blank) scan_at = PH_TRAIL;
               else if (d < 0) fault = ST_BAD_CHAR;
               else fold_value(d);
            end
            default: begin
               if (!blank) fault = ST_TRAIL_TEXT;
            end
         endcase
      end
      if (!tail) return;
      if (fault != ST_OK) begin
         step_out.push_back('{8'h00, 1'b0, fault, 1'b1});
      end else begin
         for (int k = 0; k < ones_count && step_out.size() < MAX_RESULTS; k++)
            step_out.push_back('{8'h00, 1'b1, ST_OK, 1'b0});
         top = acc_used;
         while (top > 0 && acc_store[top-1] == 8'h00) top--;
         while (top > 0 && step_out.size() < MAX_RESULTS) begin
            top--;
            step_out.push_back('{acc_store[top], 1'b1, ST_OK, 1'b0});
         end
         if (step_out.size() == 0) begin
            step_out.push_back('{8'h00, 1'b0, ST_OK, 1'b1});
         end else begin
            item = step_out.pop_back();
            item.final_item = 1'b1;
            step_out.push_back(item);
         end
      end
      clear_state();
   endfunction

   function automatic logic [7:0] blank_char();
      return ($urandom_range(5) == 5) ? CHAR_SPACE : 8'(8'h09 + $urandom_range(4));
   endfunction

   function automatic logic [7:0] any_digit();
      return digit_chars[$urandom_range(57)];
   endfunction

   task automatic push_char(input logic [7:0] ch, input logic tail, input logic typed,
                            input decoded_item_type want);
      while (!calm && $urandom_range(99) < 37) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = ch;
      req_tlast  = tail;
      do @(posedge clock); while (!req_tready);
      decode_char(ch, tail);
      if (typed) decoded_q.push_back(want);
      else foreach (step_out[i]) decoded_q.push_back(step_out[i]);
      sent++;
      @(negedge clock);
   endtask

   task automatic send_text();
      foreach (text[i]) push_char(text[i], i == text.size() - 1, 1'b0, NO_RESULT);
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (decoded_q.size() != 0) @(negedge clock);
   endtask

   task automatic add_clean();
      repeat ($urandom_range(2)) text.push_back(blank_char());
      if ($urandom_range(9) < 3) repeat ($urandom_range(3, 1)) text.push_back(CHAR_ONE);
      repeat (($urandom_range(99) < 15) ? $urandom_range(40, 11) : $urandom_range(10, 1))
         text.push_back(any_digit());
      repeat ($urandom_range(2)) text.push_back(blank_char());
   endtask

   task automatic add_broken();
      int unsigned p;
      add_clean();
      p = $urandom_range(text.size() - 1);
      case ($urandom_range(2))
         0: text[p] = 8'($urandom_range(255));
         1: text[p] = 8'h00;
         default: begin
            text.push_back(blank_char());
            text.push_back(any_digit());
         end
      endcase
   endtask

   task automatic add_long();
      int unsigned len;
      len = $urandom_range(70, 60);
      repeat (len) text.push_back(($urandom_range(3) == 0) ? CHAR_ONE : any_digit());
      if ($urandom_range(3) == 0) text[$urandom_range(len - 1)] = 8'h00;
   endtask

   task automatic report(input decoded_item_type want, input decoded_item_type got,
                         input bit orphan);
      if (mismatches < 10) begin
         if (orphan)
            $display("unexpected item: byte %02h has %0d status %0d last %0d",
                     got.value, got.present, got.code, got.final_item);
         else
            $display("mismatch: expected byte %02h has %0d status %0d last %0d, %s",
                     want.value, want.present, want.code, want.final_item,
                     $sformatf("got byte %02h has %0d status %0d last %0d",
                               got.value, got.present, got.code, got.final_item));
      end
      mismatches++;
   endtask

   always @(posedge clock) begin
      decoded_item_type got;
      decoded_item_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{rsp_tdata, rsp_tuser[0], status_type'(rsp_tuser[2:1]), rsp_tlast};
         if (decoded_q.size() == 0) begin
            report(NO_RESULT, got, 1'b1);
         end else begin
            want = decoded_q.pop_front();
            if (got.value !== want.value || got.present !== want.present ||
                got.code !== want.code || got.final_item !== want.final_item)
               report(want, got, 1'b0);
         end
      end
   end

   always @(negedge clock) begin
      if (stall_req) begin
         stall_req = 1'b0;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
         hold_left--;
         rsp_tready = 1'b0;
      end else begin
         rsp_tready = calm || ($urandom_range(99) >= 37);
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** base58_text_decoder: FAILED **");
         $finish;
      end
   end

   initial begin
      int unsigned base;
      int unsigned roll;
      bit          pressure_done;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = 8'h00;
      req_tlast   = 1'b0;
      rsp_tready  = 1'b0;
      sent        = 0;
      mismatches  = 0;
      cycle_count = 0;
      hold_left   = 0;
      calm        = 1'b0;
      stall_req   = 1'b0;
      pressure_done = 1'b0;
      clear_state();
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < SCRIPT_ROWS; r++)
         push_char(SCRIPT[r].ch, SCRIPT[r].tail, SCRIPT[r].typed, SCRIPT[r].want);
      drain();

      base = sent;
      while (sent < base + RANDOM_ITEMS) begin
         calm = (sent >= base + 140) && (sent < base + 200);
         if (!pressure_done && sent >= base + 90) begin
            drain();
            text.delete();
            repeat (MAX_CHARS) text.push_back(CHAR_ONE);
            send_text();
            stall_req = 1'b1;
            pressure_done = 1'b1;
         end
         text.delete();
         roll = $urandom_range(99);
         if (roll < 55) begin
            add_clean();
         end else if (roll < 65) begin
            repeat ($urandom_range(2)) text.push_back(blank_char());
            repeat ($urandom_range(5)) text.push_back(CHAR_ONE);
            repeat ($urandom_range(2)) text.push_back(blank_char());
            if (text.size() == 0) text.push_back(CHAR_SPACE);
         end else if (roll < 87) begin
            add_broken();
         end else if (roll < 96) begin
            repeat ($urandom_range(6, 1)) text.push_back(8'($urandom_range(255)));
         end else begin
            add_long();
         end
         send_text();
      end
      calm = 1'b0;
      drain();
      repeat (200) @(posedge clock);

      if (mismatches == 0 && decoded_q.size() == 0)
         $display("** base58_text_decoder: PASSED **");
      else
         $display("** base58_text_decoder: FAILED **");
      $finish;
   end

endmodule
